// ===== rtl/core/tes_pkg.sv =====
// ----------------------------------------------------------------------------
// Timed event scheduler package
// Shared constants: field widths, action codes, result kinds and defaults.
// ----------------------------------------------------------------------------
package tes_pkg;

  localparam int ACT_W   = 3;
  localparam int AMT_W   = 32;
  localparam int EID_W   = 16;
  localparam int KIND_W  = 2;
  localparam int TIME_W  = 48;

  localparam int SLOTS_DEF    = 16;
  localparam int ID_WIDTH_DEF = 16;

  localparam logic [ACT_W-1:0] ACT_ONCE   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_RECUR  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CANCEL = 3'd2;
  localparam logic [ACT_W-1:0] ACT_TICK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_STOP   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_START  = 3'd5;

  localparam logic [KIND_W-1:0] KIND_SCHED  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

endpackage

// ===== rtl/core/tes_if.sv =====
// ----------------------------------------------------------------------------
// Timed event scheduler channels
// Valid/ready interfaces for the action channel and the result channel.
// ----------------------------------------------------------------------------
interface tes_in_if;
  import tes_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [AMT_W-1:0] amount;
  logic [EID_W-1:0] event_id;

  modport source (output valid, action, amount, event_id, input ready);
  modport sink   (input valid, action, amount, event_id, output ready);
endinterface

interface tes_out_if;
  import tes_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [EID_W-1:0]  event_id_res;
  logic              last;

  modport source (output valid, kind, event_id_res, last, input ready);
  modport sink   (input valid, kind, event_id_res, last, output ready);
endinterface

// ===== rtl/core/timed_event_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// Timed event scheduler
// Timer table with one-shot and recurring events, cancel, tick, start, stop.
// ----------------------------------------------------------------------------
// Every schedule, cancel or tick walks the slot memory one entry a cycle
// through a single compare unit. Schedule and cancel make one pass and then
// hand over their result. A tick makes one pass per fired event plus a
// final pass, with the states FIRE1 and FIRE2 per fire to re-arm the slot
// and a result handshake for each fired event.
// Start, stop and unknown actions are taken in the idle state with no result.
// The input is not ready while a transaction is in progress.
module timed_event_scheduler_unit #(
  parameter int SLOTS    = tes_pkg::SLOTS_DEF,
  parameter int ID_WIDTH = tes_pkg::ID_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  tes_in_if.sink    in_if,
  tes_out_if.source out_if
);
  import tes_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FIRE1 = 3'd2;
  localparam logic [2:0] S_FIRE2 = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]          state_r;
  logic [ACT_W-1:0]    op_r;
  logic [AMT_W-1:0]    amt_r;
  logic [ID_WIDTH-1:0] cid_r;
  logic [TIME_W-1:0]   now_r;
  logic [ID_WIDTH-1:0] nfid_r;
  logic                run_r;
  logic [SLOTS-1:0]    valid_r;
  logic [SLOTS-1:0]    fired_r;
  logic [CW-1:0]       cnt_r;
  logic                pv_r;
  logic [AW-1:0]       pidx_r;
  logic                found_r;
  logic [AW-1:0]       best_r;
  logic [TIME_W-1:0]   best_ft_r;
  logic [ID_WIDTH-1:0] best_id_r;
  logic [AMT_W-1:0]    best_iv_r;
  logic [TIME_W-1:0]   sum_r;
  logic                pend_r;
  logic [ID_WIDTH-1:0] pend_id_r;
  logic                ret_fire_r;
  logic                out_valid_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic [EID_W-1:0]    out_id_r;
  logic                out_last_r;

  logic                mem_we;
  logic [TIME_W-1:0]   mem_wft;
  logic [ID_WIDTH-1:0] mem_wid;
  logic [AMT_W-1:0]    mem_wiv;
  logic [TIME_W-1:0]   rft;
  logic [ID_WIDTH-1:0] rid;
  logic [AMT_W-1:0]    riv;

  logic                accept;
  logic                scan_done;
  logic                hit;
  logic                take;
  logic                sched_ok;
  logic [TIME_W-1:0]   refire;
  logic [ID_WIDTH-1:0] nfid_inc;

  tes_slot_mem #(.SLOTS(SLOTS), .ID_WIDTH(ID_WIDTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (best_r),
    .wft   (mem_wft),
    .wid   (mem_wid),
    .wiv   (mem_wiv),
    .raddr (cnt_r[AW-1:0]),
    .rft   (rft),
    .rid   (rid),
    .riv   (riv)
  );

  assign accept    = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign scan_done = (state_r == S_SCAN) && !pv_r && (cnt_r == CW'(SLOTS));
  assign sched_ok  = run_r && found_r;
  assign nfid_inc  = nfid_r + 1'b1;

  // Shared compare unit: judges the slot whose data just came out of memory.
  always_comb begin
    hit  = 1'b0;
    take = 1'b0;
    case (op_r) inside
      ACT_ONCE, ACT_RECUR: begin
        hit  = !valid_r[pidx_r];
        take = hit && !found_r;
      end
      ACT_CANCEL: begin
        hit  = valid_r[pidx_r] && (rid == cid_r) && (cid_r != '0);
        take = hit && !found_r;
      end
      ACT_TICK: begin
        hit  = valid_r[pidx_r] && !fired_r[pidx_r] && (rft <= now_r);
        take = hit && (!found_r || (rft < best_ft_r) ||
                       ((rft == best_ft_r) && (rid < best_id_r)));
      end
      default: begin
        hit  = 1'b0;
        take = 1'b0;
      end
    endcase
    if (!(state_r == S_SCAN && pv_r)) begin
      take = 1'b0;
    end
  end

  // A recurring event that fell behind is re-armed from the current time.
  assign refire = (sum_r < now_r) ? (now_r + TIME_W'(best_iv_r)) : sum_r;

  always_comb begin
    mem_we  = 1'b0;
    mem_wft = refire;
    mem_wid = best_id_r;
    mem_wiv = best_iv_r;
    if (scan_done && (op_r == ACT_ONCE || op_r == ACT_RECUR)) begin
      mem_we  = sched_ok;
      mem_wft = now_r + TIME_W'(amt_r);
      mem_wid = nfid_r;
      mem_wiv = (op_r == ACT_RECUR) ? amt_r : '0;
    end else if (state_r == S_FIRE2) begin
      mem_we  = (best_iv_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      nfid_r      <= ID_WIDTH'(1);
      run_r       <= 1'b0;
      valid_r     <= '0;
      fired_r     <= '0;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      found_r     <= 1'b0;
      pend_r      <= 1'b0;
      ret_fire_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cnt_r   <= '0;
            pv_r    <= 1'b0;
            found_r <= 1'b0;
            case (in_if.action) inside
              ACT_ONCE, ACT_RECUR, ACT_CANCEL: state_r <= S_SCAN;
              ACT_TICK: begin
                now_r   <= now_r + 1'b1;
                fired_r <= '0;
                pend_r  <= 1'b0;
                state_r <= S_SCAN;
              end
              ACT_STOP: begin
                run_r   <= 1'b0;
                valid_r <= '0;
              end
              ACT_START: run_r <= 1'b1;
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (cnt_r < CW'(SLOTS)) begin
            cnt_r <= cnt_r + 1'b1;
            pv_r  <= 1'b1;
          end else begin
            pv_r  <= 1'b0;
          end
          if (take) begin
            found_r <= 1'b1;
          end
          if (scan_done) begin
            case (op_r) inside
              ACT_ONCE, ACT_RECUR: begin
                ret_fire_r  <= 1'b0;
                state_r     <= S_OUT;
                out_valid_r <= 1'b1;
                if (sched_ok) begin
                  valid_r[best_r] <= 1'b1;
                  nfid_r <= (nfid_inc == '0) ? ID_WIDTH'(1) : nfid_inc;
                end
              end
              ACT_CANCEL: begin
                ret_fire_r  <= 1'b0;
                state_r     <= S_OUT;
                out_valid_r <= 1'b1;
                if (found_r) begin
                  valid_r[best_r] <= 1'b0;
                end
              end
              ACT_TICK: begin
                if (found_r) begin
                  fired_r[best_r] <= 1'b1;
                  if (pend_r) begin
                    ret_fire_r  <= 1'b1;
                    out_valid_r <= 1'b1;
                    state_r     <= S_OUT;
                  end else begin
                    ret_fire_r <= 1'b0;
                    state_r    <= S_FIRE1;
                  end
                end else if (pend_r) begin
                  ret_fire_r  <= 1'b0;
                  pend_r      <= 1'b0;
                  out_valid_r <= 1'b1;
                  state_r     <= S_OUT;
                end else begin
                  ret_fire_r <= 1'b0;
                  state_r    <= S_IDLE;
                end
              end
              default: begin
                ret_fire_r <= 1'b0;
                state_r    <= S_IDLE;
              end
            endcase
          end
        end
        S_FIRE1: state_r <= S_FIRE2;
        S_FIRE2: begin
          if (best_iv_r == '0) begin
            valid_r[best_r] <= 1'b0;
          end
          pend_r  <= 1'b1;
          cnt_r   <= '0;
          pv_r    <= 1'b0;
          found_r <= 1'b0;
          state_r <= S_SCAN;
        end
        S_OUT: begin
          if (out_if.ready) begin
            out_valid_r <= 1'b0;
            state_r     <= ret_fire_r ? S_FIRE1 : S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_if.action;
      amt_r <= in_if.amount;
      cid_r <= ID_WIDTH'(in_if.event_id);
    end
    if (state_r == S_SCAN && cnt_r < CW'(SLOTS)) begin
      pidx_r <= cnt_r[AW-1:0];
    end
    if (take) begin
      best_r    <= pidx_r;
      best_ft_r <= rft;
      best_id_r <= rid;
      best_iv_r <= riv;
    end
    if (state_r == S_FIRE1) begin
      sum_r <= best_ft_r + TIME_W'(best_iv_r);
    end
    if (state_r == S_FIRE2) begin
      pend_id_r <= best_id_r;
    end
    if (scan_done) begin
      case (op_r) inside
        ACT_ONCE, ACT_RECUR: begin
          out_kind_r <= sched_ok ? KIND_SCHED : KIND_REJECT;
          out_id_r   <= sched_ok ? EID_W'(nfid_r) : '0;
          out_last_r <= 1'b1;
        end
        ACT_CANCEL: begin
          out_kind_r <= found_r ? KIND_CANCEL : KIND_REJECT;
          out_id_r   <= found_r ? EID_W'(cid_r) : '0;
          out_last_r <= 1'b1;
        end
        default: begin
          out_kind_r <= KIND_FIRED;
          out_id_r   <= EID_W'(pend_id_r);
          out_last_r <= !found_r;
        end
      endcase
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = out_kind_r;
  assign out_if.event_id_res = out_id_r;
  assign out_if.last         = out_last_r;

  a_out_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_OUT))
    else $error("result valid outside the output state");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_if.ready)
    else $error("input ready while a result is pending");

  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    nfid_r != '0)
    else $error("next free id became zero");

  a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_REJECT) |-> (out_last_r && out_id_r == '0))
    else $error("malformed reject result");

  a_stopped_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !run_r |-> (valid_r == '0))
    else $error("live slot while stopped");

endmodule

// ===== rtl/core/tes_slot_mem.sv =====
// ----------------------------------------------------------------------------
// Timed event scheduler slot memory
// Fire time, id and interval of every slot; one write and one registered read.
// ----------------------------------------------------------------------------
module tes_slot_mem #(
  parameter int SLOTS    = tes_pkg::SLOTS_DEF,
  parameter int ID_WIDTH = tes_pkg::ID_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(SLOTS)-1:0]   waddr,
  input  logic [tes_pkg::TIME_W-1:0] wft,
  input  logic [ID_WIDTH-1:0]        wid,
  input  logic [tes_pkg::AMT_W-1:0]  wiv,
  input  logic [$clog2(SLOTS)-1:0]   raddr,
  output logic [tes_pkg::TIME_W-1:0] rft,
  output logic [ID_WIDTH-1:0]        rid,
  output logic [tes_pkg::AMT_W-1:0]  riv
);
  import tes_pkg::*;

  logic [TIME_W-1:0]   ft_mem [SLOTS];
  logic [ID_WIDTH-1:0] id_mem [SLOTS];
  logic [AMT_W-1:0]    iv_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      ft_mem[waddr] <= wft;
      id_mem[waddr] <= wid;
      iv_mem[waddr] <= wiv;
    end
  end

  always_ff @(posedge clk) begin
    rft <= ft_mem[raddr];
    rid <= id_mem[raddr];
    riv <= iv_mem[raddr];
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Timed event scheduler testbench
// Drives schedule, cancel, tick, start and stop transactions into the timer
// table. Expected results come from a cycle-free model of the table, and each
// result transaction is compared in order. Random idling and stalls are
// applied on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tes_pkg::*;

  localparam int NSLOT = SLOTS_DEF;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [EID_W-1:0]  id;
    logic              last;
  } timer_res_t;

  class timer_table_sb;
    bit                 live[NSLOT];
    logic [TIME_W-1:0]  due_at[NSLOT];
    logic [EID_W-1:0]   owner[NSLOT];
    logic [AMT_W-1:0]   period[NSLOT];
    logic [TIME_W-1:0]  now;
    logic [EID_W-1:0]   next_id;
    bit                 running;
    timer_res_t         awaited[$];
    int                 errors;

    function new();
      foreach (live[i]) live[i] = 0;
      now = '0;
      next_id = 1;
      running = 0;
      errors = 0;
    endfunction

    function void push(logic [KIND_W-1:0] k, logic [EID_W-1:0] id, logic l);
      timer_res_t r;
      r.kind = k;
      r.id = id;
      r.last = l;
      awaited.push_back(r);
    endfunction

    function logic [EID_W-1:0] some_live_id();
      int start;
      start = $urandom_range(NSLOT - 1);
      for (int j = 0; j < NSLOT; j++)
        if (live[(start + j) % NSLOT]) return owner[(start + j) % NSLOT];
      return 16'd0;
    endfunction

    // Works out the results of one accepted action transaction.
    function void note_action(logic [ACT_W-1:0] act, logic [AMT_W-1:0] amt,
                              logic [EID_W-1:0] eid);
      int slot;
      int best;
      int count;
      bit fired[NSLOT];
      logic [TIME_W-1:0] nxt;
      slot = -1;
      count = 0;
      case (act)
        ACT_ONCE, ACT_RECUR: begin
          if (running)
            for (int i = NSLOT - 1; i >= 0; i--) if (!live[i]) slot = i;
          if (slot < 0) begin
            push(KIND_REJECT, '0, 1'b1);
          end else begin
            live[slot] = 1;
            owner[slot] = next_id;
            due_at[slot] = now + TIME_W'(amt);
            period[slot] = (act == ACT_RECUR) ? amt : '0;
            push(KIND_SCHED, next_id, 1'b1);
            next_id = next_id + 1'b1;
            if (next_id == 0) next_id = 1;
          end
        end
        ACT_CANCEL: begin
          if (eid != 0)
            for (int i = NSLOT - 1; i >= 0; i--) if (live[i] && owner[i] == eid) slot = i;
          if (slot < 0) begin
            push(KIND_REJECT, '0, 1'b1);
          end else begin
            live[slot] = 0;
            push(KIND_CANCEL, eid, 1'b1);
          end
        end
        ACT_TICK: begin
          now = now + 1'b1;
          foreach (fired[i]) fired[i] = 0;
          forever begin
            best = -1;
            for (int i = 0; i < NSLOT; i++) begin
              if (!live[i] || fired[i] || due_at[i] > now) continue;
              if (best < 0 || due_at[i] < due_at[best] ||
                  (due_at[i] == due_at[best] && owner[i] < owner[best]))
                best = i;
            end
            if (best < 0) break;
            fired[best] = 1;
            push(KIND_FIRED, owner[best], 1'b0);
            count++;
            if (period[best] == 0) begin
              live[best] = 0;
            end else begin
              nxt = due_at[best] + TIME_W'(period[best]);
              if (nxt < now) nxt = now + TIME_W'(period[best]);
              due_at[best] = nxt;
            end
          end
          if (count > 0) awaited[$].last = 1'b1;
        end
        ACT_STOP: begin
          if (running) foreach (live[i]) live[i] = 0;
          running = 0;
        end
        ACT_START: running = 1;
        default: ;
      endcase
    endfunction

    function void check_result(timer_res_t got);
      timer_res_t exp;
      if (awaited.size() == 0) begin
        $error("unexpected result transaction kind=%0d id=%0d last=%0d",
               got.kind, got.id, got.last);
        errors++;
        return;
      end
      exp = awaited.pop_front();
      if (got.kind !== exp.kind) begin
        $error("kind: expected %0d, got %0d", exp.kind, got.kind);
        errors++;
      end
      if (got.id !== exp.id) begin
        $error("event_id_res: expected %0d, got %0d", exp.id, got.id);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  tes_in_if  in_ch();
  tes_out_if out_ch();

  timed_event_scheduler_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  timer_table_sb sb = new();
  int send_idle_pct = 12;
  int recv_stall_pct = 46;
  int hold_request = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = '0;
    in_ch.amount = '0;
    in_ch.event_id = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off counted here.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      out_ch.ready <= 1'b0;
      hold_request <= hold_request - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.kind, out_ch.event_id_res, out_ch.last});
  end

  // Offers one action and returns once the transaction is taken.
  task automatic send_action(logic [ACT_W-1:0] act, logic [AMT_W-1:0] amt,
                             logic [EID_W-1:0] eid);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.amount <= amt;
    in_ch.event_id <= eid;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_action(act, amt, eid);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic random_action();
    int r;
    logic [AMT_W-1:0] amt;
    r = $urandom_range(99);
    amt = ($urandom_range(19) == 0) ? $urandom() : $urandom_range(0, 6);
    if (!sb.running && $urandom_range(2) == 0)
      send_action(ACT_START, $urandom(), EID_W'($urandom()));
    else if (r < 28) send_action(ACT_ONCE, amt, EID_W'($urandom()));
    else if (r < 42) send_action(ACT_RECUR, amt, EID_W'($urandom()));
    else if (r < 58)
      send_action(ACT_CANCEL, $urandom(),
                  ($urandom_range(9) < 6) ? sb.some_live_id() : 16'($urandom()));
    else if (r < 93) send_action(ACT_TICK, $urandom(), EID_W'($urandom()));
    else if (r < 96) send_action(ACT_STOP, $urandom(), EID_W'($urandom()));
    else if (r < 98) send_action(ACT_START, $urandom(), EID_W'($urandom()));
    else send_action(ACT_W'($urandom_range(6, 7)), $urandom(), EID_W'($urandom()));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: rejects while stopped, zero delay, zero interval, full range.
    send_action(ACT_ONCE, 32'd3, '0);
    send_action(ACT_CANCEL, '0, '0);
    send_action(ACT_START, '0, '0);
    send_action(ACT_ONCE, 32'd0, '0);
    send_action(ACT_RECUR, 32'd0, '0);
    send_action(ACT_RECUR, 32'd1, '0);
    send_action(ACT_ONCE, 32'hFFFF_FFFF, 16'hFFFF);
    send_action(ACT_TICK, '0, '0);
    send_action(ACT_TICK, '0, '0);
    send_action(ACT_CANCEL, '0, 16'hFFFF);
    send_action(ACT_CANCEL, '0, 16'd4);
    send_action(3'd6, 32'hFFFF_FFFF, 16'hFFFF);
    send_action(3'd7, '0, '0);
    send_action(ACT_STOP, '0, '0);
    send_action(ACT_RECUR, 32'd2, '0);
    send_action(ACT_START, '0, '0);
    // Fill the table past full, with mixed delays so ties sort by id.
    for (int i = 0; i < NSLOT + 1; i++) send_action(ACT_ONCE, 32'(2 - i % 3), '0);
    send_action(ACT_TICK, '0, '0);
    send_action(ACT_TICK, '0, '0);
    send_action(ACT_TICK, '0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 46;
        recv_stall_pct = 12;
        hold_request = 600;
      end else if (phase == 2) begin
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      for (int n = 0; n < 115; n++) random_action();
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule
